/* rtl/mqspm_pkg.sv */
package mqspm_pkg;

    localparam int NUM_QUEUES_DEF    = 4;
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PAYLOAD_WIDTH_DEF = 32;
    localparam int CFG_REGS          = 4;

    typedef enum logic [1:0] {
        MODE_SEND  = 2'd0,
        MODE_RECV  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_DISABLED = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE = 3'd0;
    localparam logic [2:0] REG_CAP0   = 3'd1;
    localparam logic [2:0] REG_CAP3   = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  queue_id;
        logic [3:0]  msg_priority;
        logic [31:0] msg_payload;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_payload;
        logic [3:0]  out_priority;
        logic [31:0] out_msg_id;
        logic [31:0] out_stamp;
        logic [4:0]  queue_count;
        logic        queue_empty;
        logic        queue_full;
    } rsp_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

/* rtl/mqspm_ctrl.sv */
module mqspm_ctrl
    import mqspm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = done_reg;
    assign cmd.load = (state_reg == S_IDLE) && start;
    assign cmd.exec = (state_reg == S_EXEC);

    // a result beat comes only after the execute state
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result beat without execute cycle");

    // accepted beat moves to execute
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat not executed");

    // execute always ends with a result beat and a return to idle
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execute longer than one cycle");

endmodule

/* rtl/mqspm_dp.sv */
module mqspm_dp
    import mqspm_pkg::*;
#(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  req_t       req,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data,
    output rsp_t       rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = PAYLOAD_WIDTH;

    // entry cells, kept sorted from slot 0
    logic [PW-1:0] pay_reg  [NUM_QUEUES][QUEUE_DEPTH];
    logic [3:0]    pri_reg  [NUM_QUEUES][QUEUE_DEPTH];
    logic [31:0]   id_reg   [NUM_QUEUES][QUEUE_DEPTH];
    logic [31:0]   stp_reg  [NUM_QUEUES][QUEUE_DEPTH];
    logic [PW-1:0] pay_next [NUM_QUEUES][QUEUE_DEPTH];
    logic [3:0]    pri_next [NUM_QUEUES][QUEUE_DEPTH];
    logic [31:0]   id_next  [NUM_QUEUES][QUEUE_DEPTH];
    logic [31:0]   stp_next [NUM_QUEUES][QUEUE_DEPTH];

    logic [CW-1:0] cnt_reg  [NUM_QUEUES];
    logic [4:0]    cap_reg  [CFG_REGS];
    logic [3:0]    en_reg;
    logic [31:0]   msg_id_reg;
    logic [31:0]   stamp_reg;
    req_t          req_reg;
    rsp_t          rsp_reg, rsp_next;

    logic [CW-1:0] cap_eff [NUM_QUEUES];
    logic [CW-1:0] n_sel, cap_sel, n_after;
    logic          en_sel, q_valid, do_send, do_recv, do_clear;
    logic [PW-1:0] h_pay;
    logic [3:0]    h_pri;
    logic [31:0]   h_id, h_stp;
    status_t       st;

    // effective capacity, saturated to the depth
    always_comb
    begin
        for (int g = 0; g < NUM_QUEUES; g++)
        begin
            if (32'(cap_reg[g]) > 32'(QUEUE_DEPTH))
                cap_eff[g] = CW'(QUEUE_DEPTH);
            else
                cap_eff[g] = CW'(cap_reg[g]);
        end
    end

    // addressed queue view
    always_comb
    begin
        n_sel   = '0;
        cap_sel = '0;
        en_sel  = 1'b0;
        h_pay   = '0;
        h_pri   = '0;
        h_id    = '0;
        h_stp   = '0;
        for (int g = 0; g < NUM_QUEUES; g++)
        begin
            if (req_reg.queue_id == 3'(g))
            begin
                n_sel   = cnt_reg[g];
                cap_sel = cap_eff[g];
                en_sel  = en_reg[g];
                h_pay   = pay_reg[g][0];
                h_pri   = pri_reg[g][0];
                h_id    = id_reg[g][0];
                h_stp   = stp_reg[g][0];
            end
        end
    end

    // operation decode
    always_comb
    begin
        q_valid  = (32'(req_reg.queue_id) < 32'(NUM_QUEUES));
        do_send  = 1'b0;
        do_recv  = 1'b0;
        do_clear = 1'b0;
        st       = ST_OK;
        n_after  = n_sel;
        priority if (!q_valid)
            st = ST_BAD_ID;
        else if (!en_sel)
            st = ST_DISABLED;
        else
        begin
            unique case (mode_t'(req_reg.mode))
                MODE_SEND:
                begin
                    if (n_sel >= cap_sel)
                        st = ST_FULL;
                    else
                    begin
                        do_send = 1'b1;
                        n_after = n_sel + CW'(1);
                    end
                end
                MODE_RECV:
                begin
                    if (n_sel == '0)
                        st = ST_EMPTY;
                    else
                    begin
                        do_recv = 1'b1;
                        n_after = n_sel - CW'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    do_clear = 1'b1;
                    n_after  = '0;
                end
                MODE_QUERY:
                begin
                    st = ST_OK;
                end
                default:
                begin
                    st = ST_OK;
                end
            endcase
        end
    end

    // result beat
    always_comb
    begin
        rsp_next              = '0;
        rsp_next.status       = st;
        rsp_next.queue_empty  = 1'b1;
        rsp_next.queue_full   = 1'b1;
        if (q_valid && en_sel)
        begin
            rsp_next.queue_count = 5'(n_after);
            rsp_next.queue_empty = (n_after == '0);
            rsp_next.queue_full  = (n_after >= cap_sel);
        end
        if (do_send)
        begin
            rsp_next.out_msg_id = msg_id_reg;
            rsp_next.out_stamp  = stamp_reg;
        end
        if (do_recv)
        begin
            rsp_next.out_payload  = 32'(h_pay);
            rsp_next.out_priority = h_pri;
            rsp_next.out_msg_id   = h_id;
            rsp_next.out_stamp    = h_stp;
        end
    end

    // compare-and-shift cells: insert behind equal or higher priority, or pop
    always_comb
    begin
        logic ge_cur, ge_prev;
        int   prv, nxt;
        for (int g = 0; g < NUM_QUEUES; g++)
        begin
            ge_prev = 1'b1;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                // neighbor slots, held inside the queue at both ends
                prv = (i > 0) ? i - 1 : 0;
                nxt = (i < QUEUE_DEPTH - 1) ? i + 1 : QUEUE_DEPTH - 1;
                ge_cur = (i < int'(cnt_reg[g])) && (pri_reg[g][i] >= req_reg.msg_priority);
                pay_next[g][i] = pay_reg[g][i];
                pri_next[g][i] = pri_reg[g][i];
                id_next[g][i]  = id_reg[g][i];
                stp_next[g][i] = stp_reg[g][i];
                if (req_reg.queue_id == 3'(g))
                begin
                    if (do_send && !ge_cur)
                    begin
                        if (ge_prev)
                        begin
                            pay_next[g][i] = PW'(req_reg.msg_payload);
                            pri_next[g][i] = req_reg.msg_priority;
                            id_next[g][i]  = msg_id_reg;
                            stp_next[g][i] = stamp_reg;
                        end
                        else
                        begin
                            pay_next[g][i] = pay_reg[g][prv];
                            pri_next[g][i] = pri_reg[g][prv];
                            id_next[g][i]  = id_reg[g][prv];
                            stp_next[g][i] = stp_reg[g][prv];
                        end
                    end
                    else if (do_recv && (i < QUEUE_DEPTH - 1))
                    begin
                        pay_next[g][i] = pay_reg[g][nxt];
                        pri_next[g][i] = pri_reg[g][nxt];
                        id_next[g][i]  = id_reg[g][nxt];
                        stp_next[g][i] = stp_reg[g][nxt];
                    end
                end
                ge_prev = ge_cur;
            end
        end
    end

    // entry cells, request beat and result beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
        begin
            pay_reg <= pay_next;
            pri_reg <= pri_next;
            id_reg  <= id_next;
            stp_reg <= stp_next;
            rsp_reg <= rsp_next;
        end
    end

    // counts, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_QUEUES; g++)
                cnt_reg[g] <= '0;
            for (int r = 0; r < CFG_REGS; r++)
                cap_reg[r] <= 5'd16;
            en_reg     <= '0;
            msg_id_reg <= '0;
            stamp_reg  <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                for (int g = 0; g < NUM_QUEUES; g++)
                begin
                    if (req_reg.queue_id == 3'(g) && (do_send || do_recv || do_clear))
                        cnt_reg[g] <= n_after;
                end
                if (do_send)
                begin
                    msg_id_reg <= msg_id_reg + 32'd1;
                    stamp_reg  <= stamp_reg + 32'd1;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_ENABLE)
                begin
                    en_reg <= cfg_data[3:0];
                    for (int g = 0; g < NUM_QUEUES; g++)
                    begin
                        if (cfg_data[g] != en_reg[g])
                            cnt_reg[g] <= '0;
                    end
                end
                else if (cfg_index >= REG_CAP0 && cfg_index <= REG_CAP3)
                begin
                    for (int r = 0; r < CFG_REGS; r++)
                    begin
                        if (cfg_index == 3'(r + 1))
                            cap_reg[r] <= cfg_data;
                    end
                    for (int g = 0; g < NUM_QUEUES; g++)
                    begin
                        if (cfg_index == 3'(g + 1))
                            cnt_reg[g] <= '0;
                    end
                end
            end
        end
    end

    assign rsp = rsp_reg;

endmodule

/* rtl/multi_queue_stable_priority_mailbox_unit.sv */
// a command beat taken with start is registered and then executed in the execute state
//   of the controller, in which the compare-and-shift cells of the addressed queue
//   update and the result beat is registered; no new command is taken while busy
// the result beat is shown with done for one cycle and cannot be stalled
// reset: asynchronous, clears fill counts, id and stamp counters, enable mask,
//   capacities to sixteen; entry cells are not cleared
module multi_queue_stable_priority_mailbox_unit
    import mqspm_pkg::*;
#(
    parameter int NUM_QUEUES    = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  req_t       req,
    output logic       done,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data
);

    cmd_t cmd;

    // sequencer
    mqspm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // queue storage and operations
    mqspm_dp #(
        .NUM_QUEUES    (NUM_QUEUES),
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mqspm_pkg::*;

    localparam int NQ = 4;
    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    req_t req = '0;
    logic done;
    rsp_t rsp;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;

    multi_queue_stable_priority_mailbox_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mailbox shadow state
    logic [31:0] mb_payload [NQ][DEPTH];
    logic [3:0]  mb_prio [NQ][DEPTH];
    logic [31:0] mb_id [NQ][DEPTH];
    logic [31:0] mb_stamp [NQ][DEPTH];
    int unsigned mb_fill [NQ];
    logic [31:0] id_ctr, stamp_ctr;
    logic [3:0]  en_mask;
    logic [4:0]  cap_reg [NQ];

    req_t pending_cmds [$];
    rsp_t expected_rsps [$];
    int errors = 0;
    int send_idle_pct = 9;
    bit hold_send = 0;
    int quiet_cycles = 0;

    function automatic void shadow_config(logic [2:0] idx, logic [4:0] val);
        logic [3:0] changed;
        if (idx == REG_ENABLE)
        begin
            changed = val[3:0] ^ en_mask;
            for (int q = 0; q < NQ; q++)
                if (changed[q]) mb_fill[q] = 0;
            en_mask = val[3:0];
        end
        else if (idx >= REG_CAP0 && idx <= REG_CAP3)
        begin
            cap_reg[idx - REG_CAP0] = val;
            mb_fill[idx - REG_CAP0] = 0;
        end
    endfunction

    function automatic rsp_t mailbox_predict(req_t c);
        rsp_t r;
        int q, n, cap, pos;
        r = '0;
        r.queue_empty = 1'b1;
        r.queue_full = 1'b1;
        q = c.queue_id;
        if (q >= NQ) r.status = ST_BAD_ID;
        else if (!en_mask[q]) r.status = ST_DISABLED;
        else
        begin
            cap = (cap_reg[q] > DEPTH) ? DEPTH : cap_reg[q];
            n = mb_fill[q];
            r.status = ST_OK;
            case (mode_t'(c.mode))
                MODE_SEND:
                    if (n >= cap) r.status = ST_FULL;
                    else
                    begin
                        pos = 0;
                        while (pos < n && mb_prio[q][pos] >= c.msg_priority) pos++;
                        for (int i = n; i > pos; i--)
                        begin
                            mb_payload[q][i] = mb_payload[q][i-1];
                            mb_prio[q][i] = mb_prio[q][i-1];
                            mb_id[q][i] = mb_id[q][i-1];
                            mb_stamp[q][i] = mb_stamp[q][i-1];
                        end
                        mb_payload[q][pos] = c.msg_payload;
                        mb_prio[q][pos] = c.msg_priority;
                        mb_id[q][pos] = id_ctr;
                        mb_stamp[q][pos] = stamp_ctr;
                        r.out_msg_id = id_ctr;
                        r.out_stamp = stamp_ctr;
                        id_ctr++;
                        stamp_ctr++;
                        mb_fill[q] = n + 1;
                    end
                MODE_RECV:
                    if (n == 0) r.status = ST_EMPTY;
                    else
                    begin
                        r.out_payload = mb_payload[q][0];
                        r.out_priority = mb_prio[q][0];
                        r.out_msg_id = mb_id[q][0];
                        r.out_stamp = mb_stamp[q][0];
                        for (int i = 1; i < n; i++)
                        begin
                            mb_payload[q][i-1] = mb_payload[q][i];
                            mb_prio[q][i-1] = mb_prio[q][i];
                            mb_id[q][i-1] = mb_id[q][i];
                            mb_stamp[q][i-1] = mb_stamp[q][i];
                        end
                        mb_fill[q] = n - 1;
                    end
                MODE_CLEAR: mb_fill[q] = 0;
                default: ;
            endcase
            r.queue_count = 5'(mb_fill[q]);
            r.queue_empty = (mb_fill[q] == 0);
            r.queue_full = (mb_fill[q] >= cap);
        end
        return r;
    endfunction

    // command driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_rsps.push_back(mailbox_predict(req));
            if (start && busy)
                ;
            else if (pending_cmds.size() > 0 && !hold_send &&
                     $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                req <= pending_cmds.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rsp_t exp_r;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", rsp);
            end
            else
            begin
                exp_r = expected_rsps.pop_front();
                if (rsp.status !== exp_r.status || rsp.out_payload !== exp_r.out_payload ||
                    rsp.out_priority !== exp_r.out_priority ||
                    rsp.out_msg_id !== exp_r.out_msg_id ||
                    rsp.out_stamp !== exp_r.out_stamp ||
                    rsp.queue_count !== exp_r.queue_count ||
                    rsp.queue_empty !== exp_r.queue_empty ||
                    rsp.queue_full !== exp_r.queue_full)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, rsp);
                end
            end
        end
    end

    // watchdog on accepted beats and result beats
    always @(posedge clk)
    begin
        if ((start && !busy) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic req_t make_cmd(logic [1:0] m, logic [2:0] q, logic [3:0] p,
                                      logic [31:0] d);
        req_t c;
        c.mode = m;
        c.queue_id = q;
        c.msg_priority = p;
        c.msg_payload = d;
        return c;
    endfunction

    function automatic req_t rand_cmd();
        int sel;
        logic [1:0] m;
        logic [2:0] q;
        sel = $urandom_range(99);
        if (sel < 50) m = MODE_SEND;
        else if (sel < 85) m = MODE_RECV;
        else if (sel < 92) m = MODE_CLEAR;
        else m = MODE_QUERY;
        q = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
        return make_cmd(m, q, 4'($urandom), $urandom);
    endfunction

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || start)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        shadow_config(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        id_ctr = '0;
        stamp_ctr = '0;
        en_mask = '0;
        for (int q = 0; q < NQ; q++)
        begin
            cap_reg[q] = 5'd16;
            mb_fill[q] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: disabled queues and bad ids before enabling
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_QUERY, 3'd7, 4'hf, 32'hffffffff));
        drain();
        write_reg(REG_ENABLE, 5'h0f);
        write_reg(REG_CAP0 + 3'd1, 5'd2);
        write_reg(REG_CAP0 + 3'd2, 5'd0);
        write_reg(REG_CAP0 + 3'd3, 5'd31);
        write_reg(3'd6, 5'd5);
        // directed: ordering, full, empty, clear, extremes
        pending_cmds.push_back(make_cmd(MODE_RECV, 3'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd0, 4'd3, 32'h1));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd0, 4'd3, 32'h2));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd0, 4'hf, 32'hffffffff));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_QUERY, 3'd0, 4'd0, 32'h0));
        for (int i = 0; i < 5; i++)
            pending_cmds.push_back(make_cmd(MODE_RECV, 3'd0, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd1, 4'd1, 32'h5));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd1, 4'd2, 32'h6));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd1, 4'd2, 32'h7));
        pending_cmds.push_back(make_cmd(MODE_SEND, 3'd2, 4'd2, 32'h7));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, 3'd1, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_QUERY, 3'd3, 4'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_CLEAR, 3'd5, 4'd0, 32'h0));
        drain();

        // random phases with shifting configuration and idling
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = (ph < 3) ? 9 : (ph < 6) ? 79 : 0;
            write_reg(REG_ENABLE, 5'($urandom));
            for (int q = 0; q < NQ; q++)
                if ($urandom_range(2) == 0)
                    write_reg(REG_CAP0 + 3'(q), (ph == 7) ? 5'd1 : 5'($urandom_range(18)));
            if (ph == 0) write_reg(REG_ENABLE, 5'h1f);
            for (int i = 0; i < 250; i++)
            begin
                pending_cmds.push_back(rand_cmd());
                if (i == 120 && ph == 4)
                begin
                    // hold sending until every result is back
                    while (pending_cmds.size() > 0 || start) @(posedge clk);
                    hold_send = 1;
                    while (expected_rsps.size() > 0) @(posedge clk);
                    hold_send = 0;
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && expected_rsps.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

/* multi_queue_stable_priority_mailbox_unit.f */
rtl/mqspm_pkg.sv
rtl/mqspm_ctrl.sv
rtl/mqspm_dp.sv
rtl/multi_queue_stable_priority_mailbox_unit.sv
tb/tb.sv
